// ===== rtl/core/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// Shared entry layout, constants and a fixed-point helper for the eviction table.
// ----------------------------------------------------------------------------
package sce_pkg;

   localparam int TAG_W   = 31;
   localparam int FREQ_W  = 16;
   localparam int REC_W   = 17;
   localparam int SCORE_W = 33;
   localparam int DEC_W   = 16;
   localparam int OCC_W   = 9;

   localparam logic [FREQ_W-1:0] FREQ_MAX        = 16'hFFFF;
   localparam logic [REC_W-1:0]  REC_ONE         = 17'h10000;
   localparam logic [DEC_W-1:0]  MISS_DECAY_RST  = 16'd58982;

   typedef enum logic [1:0] {
      OP_TOUCH  = 2'd0,
      OP_TICK   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [FREQ_W-1:0]  freq;
      logic [REC_W-1:0]   rec;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // recency * Q0.16 multiplier, truncated back to Q1.16
   function automatic logic [REC_W-1:0] decay_mul(input logic [REC_W-1:0] rec,
                                                  input logic [DEC_W-1:0] d);
      logic [REC_W+DEC_W-1:0] prod;
      begin
         prod = (REC_W+DEC_W)'(rec) * (REC_W+DEC_W)'(d);
         return prod[REC_W+DEC_W-1:DEC_W];
      end
   endfunction

endpackage

// ===== rtl/core/score_based_cache_eviction_unit.sv =====
// ----------------------------------------------------------------------------
// score_based_cache_eviction_unit
// Frequency/recency scored tag table with lowest-score eviction.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for exactly one cycle with rsp_valid high, and the
// receiver cannot stall it. Every entry visit is a read of the entry RAM
// followed by an evaluation of the registered read data. A lookup or a hitting
// touch searches the held entries, a missing touch with room searches and then
// appends, a missing touch on a full table searches, then makes one combined
// shift-and-decay pass, then appends, and a tick reads, multiplies the recency
// and multiplies the score for each entry. An unused opcode answers on the next
// cycle. The entry RAM needs no clearing: only entries below the fill count are
// ever read.
// ----------------------------------------------------------------------------
module score_based_cache_eviction_unit
   import sce_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [TAG_W-1:0]   req_block_tag,
   input  logic [DEC_W-1:0]   req_decay_factor,
   input  logic               csr_wr_en,
   input  logic [DEC_W-1:0]   csr_wr_data,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic               rsp_evicted_valid,
   output logic [TAG_W-1:0]   rsp_evicted_tag,
   output logic               rsp_present,
   output logic [OCC_W-1:0]   rsp_occupancy
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [OCC_W-1:0] CAP_N = OCC_W'(CAPACITY);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_S_RD  = 8'b0000_0010,
      ST_S_CHK = 8'b0000_0100,
      ST_SH_RD = 8'b0000_1000,
      ST_SH_WR = 8'b0001_0000,
      ST_AP_WR = 8'b0010_0000,
      ST_TK_RD = 8'b0100_0000,
      ST_TK_MUL= 8'b1000_0000
   } state_type;

   // tick needs a third step per entry; reuse a flag to split multiply phases
   state_type          state_ff, state_in;
   logic               tsc_ff, tsc_in;
   opcode_type         op_ff, op_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [DEC_W-1:0]   dec_ff, dec_in;
   logic [DEC_W-1:0]   mdecay_ff, mdecay_in;
   logic [OCC_W-1:0]   fill_ff, fill_in;
   logic [OCC_W-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]      vic_ff, vic_in;
   logic [SCORE_W-1:0] min_ff, min_in;
   logic [TAG_W-1:0]   vtag_ff, vtag_in;
   entry_type          hold_ff, hold_in;
   logic               valid_ff, valid_in;
   logic               hit_ff, hit_in;
   logic               pres_ff, pres_in;
   logic               evv_ff, evv_in;
   logic [TAG_W-1:0]   evtag_ff, evtag_in;

   logic [AW-1:0]      rd_addr;
   entry_type          rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_data;

   entry_type          fresh;
   logic [OCC_W-1:0]   src;
   logic [FREQ_W-1:0]  freq_up;

   // No pass uses read data of an entry it has already written: every pass reads
   // an entry before it writes that entry, so no forwarding path is needed.
   sce_entry_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_present       = pres_ff;
   assign rsp_evicted_valid = evv_ff;
   assign rsp_evicted_tag   = evtag_ff;
   // fill count already holds the post-item value during the strobe cycle
   assign rsp_occupancy     = fill_ff;

   always_comb begin
      fresh.tag   = tag_ff;
      fresh.freq  = FREQ_W'(1);
      fresh.rec   = REC_ONE;
      fresh.score = SCORE_W'(REC_ONE);
      freq_up     = (rd_data.freq < FREQ_MAX) ? rd_data.freq + FREQ_W'(1) : rd_data.freq;
      // shift source: entries past the victim move down by one
      src = (cnt_ff[AW-1:0] >= vic_ff) ? cnt_ff + OCC_W'(1) : cnt_ff;
   end

   always_comb begin
      state_in  = state_ff;
      tsc_in    = tsc_ff;
      op_in     = op_ff;
      tag_in    = tag_ff;
      dec_in    = dec_ff;
      mdecay_in = csr_wr_en ? csr_wr_data : mdecay_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      vic_in    = vic_ff;
      min_in    = min_ff;
      vtag_in   = vtag_ff;
      hold_in   = hold_ff;
      valid_in  = 1'b0;
      hit_in    = hit_ff;
      pres_in   = pres_ff;
      evv_in    = evv_ff;
      evtag_in  = evtag_ff;
      rd_addr   = cnt_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = cnt_ff[AW-1:0];
      wr_data   = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = opcode_type'(req_opcode);
               tag_in   = req_block_tag;
               dec_in   = req_decay_factor;
               cnt_in   = '0;
               tsc_in   = 1'b0;
               hit_in   = 1'b0;
               pres_in  = 1'b0;
               evv_in   = 1'b0;
               evtag_in = '0;
               unique case (opcode_type'(req_opcode))
                  OP_TOUCH: begin
                     if (fill_ff == '0) begin
                        // empty table: append straight away
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data.tag   = req_block_tag;
                        wr_data.freq  = FREQ_W'(1);
                        wr_data.rec   = REC_ONE;
                        wr_data.score = SCORE_W'(REC_ONE);
                        fill_in   = OCC_W'(1);
                        valid_in  = 1'b1;
                     end else begin
                        state_in = ST_S_RD;
                     end
                  end
                  OP_LOOKUP: begin
                     if (fill_ff == '0) valid_in = 1'b1;
                     else state_in = ST_S_RD;
                  end
                  OP_TICK: begin
                     if (fill_ff == '0) valid_in = 1'b1;
                     else state_in = ST_TK_RD;
                  end
                  default: valid_in = 1'b1;
               endcase
            end
         end

         ST_S_RD: state_in = ST_S_CHK;

         ST_S_CHK: begin
            if (rd_data.tag == tag_ff) begin
               if (op_ff == OP_TOUCH) begin
                  hit_in        = 1'b1;
                  wr_en         = 1'b1;
                  wr_data.freq  = freq_up;
                  wr_data.rec   = REC_ONE;
                  wr_data.score = SCORE_W'({freq_up, 16'h0000});
               end else begin
                  pres_in = 1'b1;
               end
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // track the first lowest score
               if (cnt_ff == '0 || rd_data.score < min_ff) begin
                  min_in  = rd_data.score;
                  vic_in  = cnt_ff[AW-1:0];
                  vtag_in = rd_data.tag;
               end
               if (cnt_ff + OCC_W'(1) == fill_ff) begin
                  if (op_ff != OP_TOUCH) begin
                     valid_in = 1'b1;
                     state_in = ST_IDLE;
                  end else if (fill_ff < CAP_N) begin
                     wr_en    = 1'b1;
                     wr_addr  = fill_ff[AW-1:0];
                     wr_data  = fresh;
                     fill_in  = fill_ff + OCC_W'(1);
                     valid_in = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     evv_in   = 1'b1;
                     evtag_in = (cnt_ff == '0 || rd_data.score < min_ff) ? rd_data.tag
                                                                        : vtag_ff;
                     cnt_in   = '0;
                     state_in = (CAPACITY > 1) ? ST_SH_RD : ST_AP_WR;
                  end
               end else begin
                  cnt_in   = cnt_ff + OCC_W'(1);
                  state_in = ST_S_RD;
               end
            end
         end

         ST_SH_RD: begin
            rd_addr  = src[AW-1:0];
            state_in = ST_SH_WR;
         end

         ST_SH_WR: begin
            // drop the victim and decay survivors; score stays as it was
            wr_en       = 1'b1;
            wr_data.rec = decay_mul(rd_data.rec, mdecay_ff);
            cnt_in      = cnt_ff + OCC_W'(1);
            state_in    = (cnt_ff + OCC_W'(2) == CAP_N) ? ST_AP_WR : ST_SH_RD;
         end

         ST_AP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(CAP_N - OCC_W'(1));
            wr_data  = fresh;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end

         ST_TK_RD: state_in = ST_TK_MUL;

         ST_TK_MUL: begin
            if (!tsc_ff) begin
               // first step: new recency into the holding register
               hold_in     = rd_data;
               hold_in.rec = decay_mul(rd_data.rec, dec_ff);
               tsc_in      = 1'b1;
            end else begin
               wr_en         = 1'b1;
               wr_data       = hold_ff;
               wr_data.score = SCORE_W'(hold_ff.freq) * SCORE_W'(hold_ff.rec);
               tsc_in        = 1'b0;
               if (cnt_ff + OCC_W'(1) == fill_ff) begin
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + OCC_W'(1);
                  state_in = ST_TK_RD;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tsc_ff    <= 1'b0;
         fill_ff   <= '0;
         mdecay_ff <= MISS_DECAY_RST;
         valid_ff  <= 1'b0;
         hit_ff    <= 1'b0;
         pres_ff   <= 1'b0;
         evv_ff    <= 1'b0;
         evtag_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         tsc_ff    <= tsc_in;
         fill_ff   <= fill_in;
         mdecay_ff <= mdecay_in;
         valid_ff  <= valid_in;
         hit_ff    <= hit_in;
         pres_ff   <= pres_in;
         evv_ff    <= evv_in;
         evtag_ff  <= evtag_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      tag_ff  <= tag_in;
      dec_ff  <= dec_in;
      cnt_ff  <= cnt_in;
      vic_ff  <= vic_in;
      min_ff  <= min_in;
      vtag_ff <= vtag_in;
      hold_ff <= hold_in;
   end

endmodule

// ===== rtl/core/sce_entry_ram.sv =====
// ----------------------------------------------------------------------------
// sce_entry_ram
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sce_entry_ram
   import sce_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic            clock,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data
);

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/sce_checker.sv =====
// ----------------------------------------------------------------------------
// sce_checker
// Port-level checks for the eviction table, bound to the top level.
// ----------------------------------------------------------------------------
module sce_checker
   import sce_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_hit,
   input logic             rsp_evicted_valid,
   input logic             rsp_present,
   input logic [OCC_W-1:0] rsp_occupancy
);

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_present) && !(rsp_hit && rsp_evicted_valid))
      else $error("conflicting result flags");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_occupancy == OCC_W'(CAPACITY))
      else $error("eviction without full table");

   a_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_occupancy <= OCC_W'(CAPACITY))
      else $error("occupancy above capacity");

   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without a command");

endmodule

bind score_based_cache_eviction_unit sce_checker #(.CAPACITY(CAPACITY)) u_sce_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_present       (rsp_present),
   .rsp_occupancy     (rsp_occupancy)
);
